// ===== rtl/sfcp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcp_pkg
// Shared types and constants of the scope frame packer: sample layout,
// frame byte positions and CRC-16/MODBUS parameters.
// ----------------------------------------------------------------------------
package sfcp_pkg;

	// Four channels; channel_a in the low bits so byte n of the frame is
	// bits [8n+7:8n] of the flattened sample.
	typedef struct packed {
		logic [15:0] channel_d;
		logic [15:0] channel_c;
		logic [15:0] channel_b;
		logic [15:0] channel_a;
	} sample_t;

	localparam int FrameLen = 10;
	localparam int DataLen  = 8;
	localparam int IdxW     = $clog2(FrameLen);

	typedef logic [IdxW-1:0] idx_t;

	// Byte positions within a frame
	localparam idx_t FirstIdx = idx_t'(0);
	localparam idx_t CrcLoIdx = idx_t'(DataLen);
	localparam idx_t CrcHiIdx = idx_t'(DataLen + 1);
	localparam idx_t LastIdx  = idx_t'(FrameLen - 1);

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	// Sample queue between front and back; depth is a power of two
	localparam int QueueDepth = 2;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

endpackage

// ===== rtl/scope_frame_crc16_packer.sv =====
// A pushed sample goes through the queue and the output register to the ports.
// Throughput: one byte per cycle while pop does not stall, set by the serializer.
// Samples follow back to back; a 2-entry queue takes new ones.
// Reset clears queue pointers, serializer position and output valid; data
// registers are not cleared.
// ----------------------------------------------------------------------------
// scope_frame_crc16_packer
// Packs a four-channel sample into a 10-byte frame with a CRC-16/MODBUS
// trailer, one byte per request on the output.
// ----------------------------------------------------------------------------
module scope_frame_crc16_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] channel_a,
	input  logic [15:0] channel_b,
	input  logic [15:0] channel_c,
	input  logic [15:0] channel_d,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  frame_byte,
	output logic        frame_end
);
	import sfcp_pkg::*;

	sample_t sample_in;
	sample_t head_sample;
	logic    head_valid;
	logic    head_take;

	assign sample_in = '{channel_d: channel_d, channel_c: channel_c,
		channel_b: channel_b, channel_a: channel_a};

	sfcp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_in   (sample_in),
		.head_valid  (head_valid),
		.head_sample (head_sample),
		.head_take   (head_take)
	);

	sfcp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_sample (head_sample),
		.head_take   (head_take),
		.empty       (empty),
		.pop         (pop),
		.frame_byte  (frame_byte),
		.frame_end   (frame_end)
	);

endmodule

// ===== rtl/sfcp_front.sv =====
// ----------------------------------------------------------------------------
// sfcp_front
// Input side: accepts samples and holds them in a short queue until the
// serializer has sent the whole frame.
// ----------------------------------------------------------------------------
module sfcp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  sfcp_pkg::sample_t sample_in,
	output logic              head_valid,
	output sfcp_pkg::sample_t head_sample,
	input  logic              head_take
);
	import sfcp_pkg::*;

	sample_t            mem_q [QueueDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QCntW-1:0]   count_q;
	logic               wr_en;
	logic               rd_en;

	assign full        = (count_q == QCntW'(QueueDepth));
	assign head_valid  = (count_q != '0);
	assign head_sample = mem_q[rd_ptr_q];
	assign wr_en       = push && !full;
	assign rd_en       = head_take && head_valid;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= sample_in;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + QCntW'(1);
				2'b01:   count_q <= count_q - QCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/sfcp_back.sv =====
// ----------------------------------------------------------------------------
// sfcp_back
// Serializer: walks the head sample byte by byte, folds each data byte into
// the CRC and appends the CRC; one output register decouples the pop side.
// ----------------------------------------------------------------------------
module sfcp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  sfcp_pkg::sample_t head_sample,
	output logic              head_take,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        frame_byte,
	output logic              frame_end
);
	import sfcp_pkg::*;

	// CRC-16/MODBUS update with one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

	idx_t        idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_end_q;
	logic        load;
	logic        is_data;
	logic [7:0]  data_byte;
	logic [7:0]  next_byte;
	logic [15:0] crc_base;

	assign load      = head_valid && (!out_valid_q || pop);
	assign head_take = load && (idx_q == LastIdx);
	assign is_data   = (idx_q < CrcLoIdx);
	assign data_byte = head_sample[{idx_q[2:0], 3'b000} +: 8];
	assign crc_base  = (idx_q == FirstIdx) ? CrcInit : crc_q;

	// Byte select for the current frame position
	always_comb begin
		if (is_data) begin
			next_byte = data_byte;
		end else if (idx_q == CrcHiIdx) begin
			next_byte = crc_q[15:8];
		end else begin
			next_byte = crc_q[7:0];
		end
	end

	// Position counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= FirstIdx;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= (idx_q == LastIdx) ? FirstIdx : idx_q + idx_t'(1);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Running CRC and output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= next_byte;
			out_end_q  <= (idx_q == LastIdx);
			if (is_data) begin
				crc_q <= crc_byte(crc_base, data_byte);
			end
		end
	end

	assign empty      = !out_valid_q;
	assign frame_byte = out_byte_q;
	assign frame_end  = out_end_q;

endmodule

// ===== rtl/sfcp_checker.sv =====
// ----------------------------------------------------------------------------
// sfcp_checker
// Port-level checks: frame framing, output hold under stall and delivery of
// queued bytes.
// ----------------------------------------------------------------------------
module sfcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  frame_byte,
	input logic        frame_end
);
	import sfcp_pkg::*;

	logic       in_req;
	logic       out_req;
	idx_t       pos_q;
	logic [5:0] pending_q;

	assign in_req  = push && !full;
	assign out_req = pop && !empty;

	// Track frame position and bytes still owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= FirstIdx;
			pending_q <= '0;
		end else begin
			if (out_req) begin
				pos_q <= (pos_q == LastIdx) ? FirstIdx : pos_q + idx_t'(1);
			end
			pending_q <= pending_q + (in_req ? 6'(FrameLen) : 6'd0)
				- (out_req ? 6'd1 : 6'd0);
		end
	end

	a_frame_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_req |-> (frame_end == (pos_q == LastIdx)))
		else $error("frame_end out of place");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(frame_end)))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 6'd0) |-> empty)
		else $error("byte shown with nothing owed");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 6'd0 && in_req) |-> ##2 !empty)
		else $error("first byte late on idle block");

	// Full only with one whole frame queued behind the unfinished head frame
	a_full_owed: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (pending_q >= 6'(FrameLen + 1)))
		else $error("full with too few bytes owed");

endmodule

bind scope_frame_crc16_packer sfcp_checker u_sfcp_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scope_frame_crc16_packer. Four-channel samples
// go in through the push side. Every sample is expanded into its expected
// 10-byte frame: channel bytes low byte first, then the CRC-16/MODBUS
// trailer. The bytes popped from the block are compared in order against
// that frame. Pacing runs in three phases: receiver-heavy idling, then
// sender-heavy idling, then no idling at all.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfcp_pkg::*;

	localparam int QuietLimit   = 2000;
	localparam int SettleCycles = 12;
	localparam int RandPerPhase = 152;

	// Expected frame bytes, oldest first
	class frame_ledger;
		typedef struct packed {
			logic [7:0] data;
			logic       last;
		} byte_slot_t;

		byte_slot_t due_bytes[$];
		int         fault_count;
		int         bytes_checked;
		int         samples_logged;

		function new();
			fault_count    = 0;
			bytes_checked  = 0;
			samples_logged = 0;
		endfunction

		// CRC-16/MODBUS over the eight channel bytes, LSB first
		function logic [15:0] crc16_modbus(sample_t s);
			logic [15:0] crc;
			crc = CrcInit;
			for (int n = 0; n < DataLen; n++) begin
				crc = crc ^ {8'h00, s[8*n +: 8]};
				for (int b = 0; b < 8; b++) begin
					if (crc[0])
						crc = (crc >> 1) ^ CrcPoly;
					else
						crc = crc >> 1;
				end
			end
			return crc;
		endfunction

		// Expand an accepted sample into its frame
		function void log_sample(sample_t s);
			logic [15:0] crc;
			byte_slot_t  slot;
			crc = crc16_modbus(s);
			for (int k = 0; k < FrameLen; k++) begin
				if (k < DataLen)
					slot.data = s[8*k +: 8];
				else if (k == DataLen)
					slot.data = crc[7:0];
				else
					slot.data = crc[15:8];
				slot.last = (k == FrameLen - 1);
				due_bytes.push_back(slot);
			end
			samples_logged++;
		endfunction

		// Compare a popped byte against the oldest expected one
		function void match_byte(logic [7:0] data, logic last);
			byte_slot_t want;
			bytes_checked++;
			if (due_bytes.size() == 0) begin
				$error("frame_byte: unexpected byte %h (frame_end %b) with no frame pending",
					data, last);
				fault_count++;
				return;
			end
			want = due_bytes.pop_front();
			if (data !== want.data) begin
				$error("frame_byte mismatch: expected %h, actual %h", want.data, data);
				fault_count++;
			end
			if (last !== want.last) begin
				$error("frame_end mismatch: expected %b, actual %b", want.last, last);
				fault_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [15:0] channel_a;
	logic [15:0] channel_b;
	logic [15:0] channel_c;
	logic [15:0] channel_d;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  frame_byte;
	logic        frame_end;

	frame_ledger ledger = new();
	int          send_idle_pct;
	int          recv_idle_pct;
	int          quiet_cycles;

	scope_frame_crc16_packer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.channel_a  (channel_a),
		.channel_b  (channel_b),
		.channel_c  (channel_c),
		.channel_d  (channel_d),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.frame_end  (frame_end)
	);

	always #5 clk = ~clk;

	// Output side: random pop stalls, driven on the falling edge
	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Check each accepted frame byte
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			ledger.match_byte(frame_byte, frame_end);
	end

	// Watchdog: stop if neither side moves a request for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one sample; called and returns at a falling edge
	task automatic send_sample(input logic [15:0] a, input logic [15:0] b,
		input logic [15:0] c, input logic [15:0] d);
		logic    took;
		sample_t s;
		s.channel_a = a;
		s.channel_b = b;
		s.channel_c = c;
		s.channel_d = d;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push      <= 1'b1;
		channel_a <= a;
		channel_b <= b;
		channel_c <= c;
		channel_d <= d;
		do begin
			@(posedge clk);
			took = !full;
			if (took)
				ledger.log_sample(s);
			@(negedge clk);
		end while (!took);
	endtask

	// Channel word biased toward extremes and single-bit patterns
	function automatic logic [15:0] pick_channel_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0001 << $urandom_range(15);
			3: return ~(16'h0001 << $urandom_range(15));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_sample(pick_channel_word(), pick_channel_word(),
				pick_channel_word(), pick_channel_word());
	endtask

	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		channel_a     = '0;
		channel_b     = '0;
		channel_c     = '0;
		channel_d     = '0;
		quiet_cycles  = 0;
		send_idle_pct = 20;
		recv_idle_pct = 51;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, one hot channel, alternating bit patterns
		send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		send_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		send_sample(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00);
		send_sample(16'h0001, 16'h8000, 16'h0100, 16'h0080);
		send_sample(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
		send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0001);
		send_random(RandPerPhase);

		// Sender now stalls more than the receiver
		send_idle_pct = 51;
		recv_idle_pct = 20;
		send_random(RandPerPhase);

		// Back to back, no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(RandPerPhase);
		push <= 1'b0;

		// Drain, then give the block time to show any stray bytes
		while (ledger.due_bytes.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);

		if (ledger.due_bytes.size() != 0) begin
			$error("frame_byte: %0d expected bytes never arrived",
				ledger.due_bytes.size());
			ledger.fault_count++;
		end
		$display("Covered %0d samples and %0d frame bytes across three pacing phases,",
			ledger.samples_logged, ledger.bytes_checked);
		$display("with %0d mismatches found.", ledger.fault_count);
		if (ledger.fault_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
